>>> hw/rtl/ncc_pkg.sv
package ncc_pkg;

    localparam int REG_COUNT     = 4;
    localparam int NUM_CASES_DEF = 4;
    localparam int FEAT_W        = 8;
    localparam int SAT_W         = 7;
    localparam int LABEL_W       = 3;
    localparam int INDEX_W       = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 27;
    // Three squared 8-bit differences: at most 3 * 255 * 255, which fits in 18 bits.
    localparam int DIST_W        = 18;
    localparam int SQ_W          = 2 * FEAT_W;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 8;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [FEAT_W-1:0]  sat;
        logic [FEAT_W-1:0]  sys;
        logic [FEAT_W-1:0]  pulse;
    } case_word_t;

    typedef struct packed {
        logic [FEAT_W-1:0] pulse;
        logic [FEAT_W-1:0] sys;
        logic [FEAT_W-1:0] sat;
    } feat_diff_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    localparam case_word_t CASE_RESET [REG_COUNT] = '{
        case_word_t'(27'd22567544),
        case_word_t'(27'd90339408),
        case_word_t'(27'd39821452),
        case_word_t'(27'd56255548)
    };

    function automatic logic [FEAT_W-1:0] abs_diff(input logic [FEAT_W-1:0] a,
                                                   input logic [FEAT_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> hw/rtl/ncc_cfg_regs.sv
module ncc_cfg_regs
    import ncc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output case_word_t             cases [REG_COUNT]
);

    case_word_t cases_reg [REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cases_reg[i] <= CASE_RESET[i];
            end
        end
        else if (cfg_valid && ({1'b0, cfg_index} < (CFG_INDEX_W + 1)'(REG_COUNT)))
        begin
            // Writes to indexes past the last case register are dropped.
            cases_reg[cfg_index[$clog2(REG_COUNT)-1:0]] <= case_word_t'(cfg_data);
        end
    end

    assign cases = cases_reg;

endmodule

>>> hw/rtl/ncc_dist_pipe.sv
module ncc_dist_pipe
    import ncc_pkg::*;
#(
    parameter int NUM_LANES = NUM_CASES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_ctl_t        ctl_in,
    input  logic [FEAT_W-1:0] pulse_rate,
    input  logic [FEAT_W-1:0] systolic_pressure,
    input  logic [SAT_W-1:0]  saturation_percent,
    input  case_word_t        cases [REG_COUNT],
    output logic              dist_valid,
    output logic [DIST_W-1:0] case_dist [NUM_LANES]
);

    // Stage one holds per-feature absolute differences, stage two the summed squares.
    feat_diff_t        diff_reg  [NUM_LANES];
    feat_diff_t        diff_next [NUM_LANES];
    logic [DIST_W-1:0] dist_reg  [NUM_LANES];
    logic [DIST_W-1:0] dist_next [NUM_LANES];
    logic              v1_reg;
    logic              v2_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            diff_next[i].pulse = abs_diff(pulse_rate, cases[i].pulse);
            diff_next[i].sys   = abs_diff(systolic_pressure, cases[i].sys);
            diff_next[i].sat   = abs_diff({1'b0, saturation_percent}, cases[i].sat);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            dist_next[i] = DIST_W'(SQ_W'(diff_reg[i].pulse * diff_reg[i].pulse))
                         + DIST_W'(SQ_W'(diff_reg[i].sys * diff_reg[i].sys))
                         + DIST_W'(SQ_W'(diff_reg[i].sat * diff_reg[i].sat));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            v1_reg <= ctl_in.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            diff_reg <= diff_next;
            dist_reg <= dist_next;
        end
    end

    assign dist_valid = v2_reg;
    assign case_dist  = dist_reg;

endmodule

>>> hw/rtl/ncc_argmin.sv
module ncc_argmin
    import ncc_pkg::*;
#(
    parameter int NUM_LANES = NUM_CASES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  stage_ctl_t         ctl_in,
    input  logic [DIST_W-1:0]  case_dist [NUM_LANES],
    input  case_word_t         cases [REG_COUNT],
    output logic               res_valid,
    output logic [LABEL_W-1:0] res_label,
    output logic [INDEX_W-1:0] res_index
);

    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_index;
    logic [LABEL_W-1:0] best_label;
    logic               valid_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [INDEX_W-1:0] index_reg;

    // Strict less-than keeps the earliest case on a tie.
    always_comb
    begin
        best_dist  = case_dist[0];
        best_index = '0;
        best_label = cases[0].label;
        for (int i = 1; i < NUM_LANES; i++)
        begin
            if (case_dist[i] < best_dist)
            begin
                best_dist  = case_dist[i];
                best_index = INDEX_W'(i);
                best_label = cases[i].label;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            label_reg <= best_label;
            index_reg <= best_index;
        end
    end

    assign res_valid = valid_reg;
    assign res_label = label_reg;
    assign res_index = index_reg;

endmodule

>>> hw/rtl/nearest_case_classifier_unit.sv
// Nearest-case classifier: one-nearest-neighbor triage on vital-sign samples.
//
// Input stream (s_*): one request per sample. s_tdata carries the pulse rate,
// systolic pressure and oxygen saturation. Output stream (m_*): one result per
// sample with the label and index of the nearest reference case; the earliest
// case wins a tie on squared distance.
// Configuration channel (cfg_*): index 0..3 selects a reference case word
// (pulse in bits 7:0, pressure 15:8, saturation 23:16, label 26:24); other
// indexes are dropped. cfg_ready is always high. Write only while idle.
//
// A request accepted on s_tready raises m_tvalid once it has passed through the
// stages in order: one stage forms
// absolute differences, one squares and sums them per case, and one picks the
// minimum into the output register. Throughput is one sample per cycle while m_tready stays high.
// All stages advance together; when the receiver holds m_tready low with a
// result waiting, the whole pipeline freezes and s_tready drops, so nothing
// is lost or repeated. Empty stages ahead of the output stay frozen as well.
// Reset clears all valid bits and loads the four default reference cases.
module nearest_case_classifier_unit
    import ncc_pkg::*;
#(
    parameter int NUM_CASES = NUM_CASES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pulse_rate [7:0], systolic_pressure [15:8], saturation_percent [22:16], zero [23]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // triage_level [2:0], nearest_index [5:3], zero [7:6]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NUM_LANES = (NUM_CASES < REG_COUNT) ? NUM_CASES : REG_COUNT;

    case_word_t         cases     [REG_COUNT];
    logic [DIST_W-1:0]  case_dist [NUM_LANES];
    logic               dist_valid;
    logic               res_valid;
    logic [LABEL_W-1:0] res_label;
    logic [INDEX_W-1:0] res_index;
    logic               advance;
    stage_ctl_t         front_ctl;
    stage_ctl_t         back_ctl;

    assign advance   = !res_valid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    assign front_ctl.valid   = s_tvalid;
    assign front_ctl.advance = advance;
    assign back_ctl.valid    = dist_valid;
    assign back_ctl.advance  = advance;

    ncc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cases     (cases)
    );

    ncc_dist_pipe #(
        .NUM_LANES (NUM_LANES)
    ) u_dist (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl_in             (front_ctl),
        .pulse_rate         (s_tdata[7:0]),
        .systolic_pressure  (s_tdata[15:8]),
        .saturation_percent (s_tdata[22:16]),
        .cases              (cases),
        .dist_valid         (dist_valid),
        .case_dist          (case_dist)
    );

    ncc_argmin #(
        .NUM_LANES (NUM_LANES)
    ) u_argmin (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (back_ctl),
        .case_dist (case_dist),
        .cases     (cases),
        .res_valid (res_valid),
        .res_label (res_label),
        .res_index (res_index)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {2'b00, res_index, res_label};

endmodule

>>> hw/rtl/ncc_checker.sv
module ncc_checker
    import ncc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // A full pipeline with a stalled receiver must refuse new requests.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted while the output is stalled");

    // With the receiver ready while it passes through, an accepted request yields a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing three cycles after the request");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("output padding bits not zero");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind nearest_case_classifier_unit ncc_checker u_ncc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
